/* hdl/ppd_pkg.sv */
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants for the pulse peak detector: sample and mean widths.
// ----------------------------------------------------------------------------
package ppd_pkg;

  // Width of one converter sample and of one filtered mean.
  localparam int unsigned SampleW = 10;

  typedef logic [SampleW-1:0] sample_t;

endpackage

/* hdl/pulse_peak_detector_top.sv */
// ----------------------------------------------------------------------------
// pulse_peak_detector_top
// Moving-average peak detector: keeps rings of raw samples and of their means
// in two small synchronous memories and flags the end of each climb.
// ----------------------------------------------------------------------------
// Sequence: once an input item is taken the block updates the sum, multiplies,
// writes the mean, sweeps the mean-ring entries for the comparison, then
// loads the output register, waiting there while the output is stalled.
// Input: no new item is taken until the result is loaded; the sweep runs over
// the single read port of the mean ring.
// Reset: asynchronous and active low; both rings read as zero, the running
// sum, write slot and climb flag are cleared, and no item is pending.
module pulse_peak_detector_top #(
  parameter int unsigned HISTORY_DEPTH = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ppd_pkg::SampleW-1:0]  sensor_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ppd_pkg::SampleW-1:0]  filtered_value_o,
  output logic                         peak_found_o,
  output logic                         climbing_o
);

  localparam int unsigned SlotW = $clog2(HISTORY_DEPTH);
  localparam int unsigned SumW  = $clog2(HISTORY_DEPTH * ((2 ** ppd_pkg::SampleW) - 1) + 1);
  // Reciprocal scaling: floor(sum * RecipM / 2^RecipK) equals sum / HISTORY_DEPTH
  // because the rounding error stays below 1 / (2 * HISTORY_DEPTH).
  localparam int unsigned RecipK = SumW + $clog2(HISTORY_DEPTH) + 1;
  localparam int unsigned RecipW = RecipK + 1;
  localparam int unsigned RecipM = ((2 ** RecipK) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam int unsigned ProdW  = SumW + RecipW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_MEAN,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e              state_q;
  ppd_pkg::sample_t    sample_q;
  logic [SumW-1:0]     sum_q;
  logic [ProdW-1:0]    prod_q;
  ppd_pkg::sample_t    mean_q;
  logic [SlotW-1:0]    slot_q;
  logic [SlotW-1:0]    cmp_idx_q;
  logic [SlotW-1:0]    cmp_idx_d;
  logic                pass_q;
  logic                climb_q;
  logic                out_valid_q;
  ppd_pkg::sample_t    out_value_q;
  logic                out_peak_q;

  // Ring memories and their per-entry valid bits; an unwritten entry reads zero.
  ppd_pkg::sample_t          raw_mem  [HISTORY_DEPTH];
  ppd_pkg::sample_t          mean_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]  raw_vld_q;
  logic [HISTORY_DEPTH-1:0]  mean_vld_q;
  ppd_pkg::sample_t          raw_rd_q;
  logic                      raw_rd_vld_q;
  ppd_pkg::sample_t          mean_rd_q;
  logic                      mean_rd_vld_q;

  logic                in_accept;
  logic                out_free;
  logic                raw_we;
  logic                mean_we;
  ppd_pkg::sample_t    raw_old;
  ppd_pkg::sample_t    mean_cmp;
  logic [SumW-1:0]     sum_d;
  logic                cmp_fail;
  logic                pass_final;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign raw_we    = (state_q == ST_SUM);
  assign mean_we   = (state_q == ST_MEAN);

  assign raw_old  = raw_rd_vld_q ? raw_rd_q : '0;
  assign mean_cmp = mean_rd_vld_q ? mean_rd_q : '0;
  assign sum_d    = sum_q - SumW'(raw_old) + SumW'(sample_q);

  // The new mean's own slot is left out of the comparison.
  assign cmp_fail = (cmp_idx_q != slot_q) &&
                    (climb_q ? (mean_q < mean_cmp) : (mean_q <= mean_cmp));
  assign pass_final = pass_q;

  always_comb begin
    cmp_idx_d = cmp_idx_q;
    if (state_q == ST_MEAN) begin
      cmp_idx_d = '0;
    end else if (state_q == ST_CMP && cmp_idx_q != LastSlot) begin
      cmp_idx_d = cmp_idx_q + 1'b1;
    end
  end

  // Raw ring: read the current slot every cycle, written once per item.
  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[slot_q] <= sample_q;
    end
    raw_rd_q <= raw_mem[slot_q];
  end

  // Mean ring: the sweep reads at the next comparison index, so the registered read data lines up with the comparison.
  // The new mean is taken from the product, as mean_q loads on the same edge.
  always_ff @(posedge clk_i) begin
    if (mean_we) begin
      mean_mem[slot_q] <= prod_q[RecipK +: ppd_pkg::SampleW];
    end
    mean_rd_q <= mean_mem[cmp_idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q     <= '0;
      mean_vld_q    <= '0;
      raw_rd_vld_q  <= 1'b0;
      mean_rd_vld_q <= 1'b0;
    end else begin
      if (raw_we) begin
        raw_vld_q[slot_q] <= 1'b1;
      end
      if (mean_we) begin
        mean_vld_q[slot_q] <= 1'b1;
      end
      raw_rd_vld_q  <= raw_vld_q[slot_q];
      mean_rd_vld_q <= mean_vld_q[cmp_idx_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      slot_q      <= '0;
      cmp_idx_q   <= '0;
      pass_q      <= 1'b0;
      climb_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_peak_q  <= 1'b0;
      out_value_q <= '0;
    end else begin
      cmp_idx_q <= cmp_idx_d;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_q   <= sum_d;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_MEAN;
        end
        ST_MEAN: begin
          pass_q  <= 1'b1;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (cmp_fail) begin
            pass_q <= 1'b0;
          end
          if (cmp_idx_q == LastSlot) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_peak_q  <= !pass_final && climb_q;
            climb_q     <= pass_final;
            out_value_q <= mean_q;
            slot_q      <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sensor_sample_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(sum_q) * ProdW'(RecipM);
    end
    if (state_q == ST_MEAN) begin
      mean_q <= prod_q[RecipK +: ppd_pkg::SampleW];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign peak_found_o     = out_peak_q;
  assign climbing_o       = climb_q;

  // A peak always ends the climb it reports.
  a_peak_clears_climb : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peak_found_o |-> !climbing_o)
    else $error("peak reported while climb flag still set");

  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("block took no work after accepting an item");

  // The write slot never leaves the ring.
  a_slot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= LastSlot)
    else $error("write slot out of range");

  // The running sum can never exceed a ring full of maximum samples.
  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SumW'(HISTORY_DEPTH * ((2 ** ppd_pkg::SampleW) - 1)))
    else $error("running sum exceeds ring maximum");

  // A new result only appears when the comparison sweep has finished.
  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result issued outside the final step");

endmodule
